// ===== sv/lcdseq_pkg.sv =====
// Shared types, constants and tables for the character LCD bus sequencer.
// Used by every module of the block; depends on nothing.
package lcdseq_pkg;

  localparam int unsigned ROW_COUNT = 4;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned INIT_BYTES = 9;
  localparam int unsigned IDX_W = $clog2(INIT_BYTES);

  localparam logic [5:0] COLUMN_LIMIT_RESET = 6'd16;
  localparam logic [6:0] POWER_UP_MS = 7'd15;
  localparam logic [6:0] CLEAR_MS = 7'd2;
  localparam logic [7:0] CMD_CLEAR = 8'h01;

  typedef enum logic [2:0] {
    FUNC_INIT   = 3'd0,
    FUNC_CHAR   = 3'd1,
    FUNC_CMD    = 3'd2,
    FUNC_CURSOR = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic [2:0] row;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic       enable;
    logic [7:0] data_bus;
    logic       then_short_wait;
    logic [6:0] then_wait_ms;
    logic       last;
  } phase_t;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic       is_init;
    logic       reg_select;
    logic [7:0] value;
    logic [6:0] wait_ms;
  } cmd_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      default: base = 8'hD4;
    endcase
    return base;
  endfunction

  function automatic logic [7:0] init_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx) inside
      4'd0, 4'd1, 4'd2, 4'd3: b = 8'h3F;
      4'd4:    b = 8'h08;
      4'd5:    b = 8'h01;
      4'd6:    b = 8'h06;
      4'd7:    b = 8'h0C;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

  function automatic logic [6:0] init_wait(input logic [IDX_W-1:0] idx);
    logic [6:0] w;
    unique case (idx)
      4'd0:    w = 7'd5;
      4'd1:    w = 7'd100;
      4'd5:    w = 7'd2;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/lcdseq_front.sv =====
// Front end: holds column_limit, classifies each accepted request into a
// bus command, and drops cursor requests out of range and unknown functions.
// Depends on lcdseq_pkg.
module lcdseq_front import lcdseq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [5:0] cfg_data_i,
  input  logic       req_valid_i,
  input  req_t       req_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  logic [5:0] column_limit_q, column_limit_d;

  always_comb begin
    column_limit_d = column_limit_q;
    if (cfg_valid_i) begin
      column_limit_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_limit_q <= COLUMN_LIMIT_RESET;
    end else begin
      column_limit_q <= column_limit_d;
    end
  end

  logic cursor_ok;
  assign cursor_ok = (req_i.column < column_limit_q) &&
                     ({29'd0, req_i.row} < ROW_COUNT);

  always_comb begin
    cmd_valid_o        = 1'b0;
    cmd_o.is_init      = 1'b0;
    cmd_o.reg_select   = 1'b0;
    cmd_o.value        = req_i.byte_value;
    cmd_o.wait_ms      = 7'd0;
    unique case (req_i.func)
      FUNC_INIT: begin
        cmd_valid_o   = req_valid_i;
        cmd_o.is_init = 1'b1;
      end
      FUNC_CHAR: begin
        cmd_valid_o      = req_valid_i;
        cmd_o.reg_select = 1'b1;
      end
      FUNC_CMD: begin
        cmd_valid_o = req_valid_i;
      end
      FUNC_CURSOR: begin
        cmd_valid_o = req_valid_i && cursor_ok;
        cmd_o.value = row_base(req_i.row[1:0]) + {2'b00, req_i.column};
      end
      FUNC_CLEAR: begin
        cmd_valid_o   = req_valid_i;
        cmd_o.value   = CMD_CLEAR;
        cmd_o.wait_ms = CLEAR_MS;
      end
      default: begin
        cmd_valid_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/lcdseq_cmd_fifo.sv =====
// Short queue of classified commands between the front and back ends.
// Depends on lcdseq_pkg.
module lcdseq_cmd_fifo import lcdseq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output cmd_t rd_data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem_q [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o    = (count_q == CNT_W'(CMD_DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = bump(wr_ptr_q);
    end
    if (rd_en_i) begin
      rd_ptr_d = bump(rd_ptr_q);
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== sv/lcdseq_back.sv =====
// Back end: steps through the pin phases of the command at the queue head,
// one phase a cycle while there is room, into a small result queue. Holds
// the bus latch. Depends on lcdseq_pkg.
module lcdseq_back import lcdseq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cmd_empty_i,
  input  cmd_t   cmd_i,
  output logic   cmd_pop_o,
  output logic   empty_o,
  input  logic   pop_i,
  output phase_t phase_o
);

  typedef enum logic [3:0] {
    ST_FIRST = 4'b0001,
    ST_SEL   = 4'b0010,
    ST_RISE  = 4'b0100,
    ST_FALL  = 4'b1000
  } state_e;

  localparam int unsigned PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       bus_latch_q, bus_latch_d;

  phase_t           out_mem_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic   out_full, emit, do_pop;
  phase_t ph;
  logic       cur_rs;
  logic [7:0] cur_value;
  logic [6:0] cur_ms;

  assign out_full = (count_q == CNT_W'(OUT_DEPTH));
  assign empty_o  = (count_q == '0);
  assign do_pop   = pop_i && !empty_o;
  assign emit     = !cmd_empty_i && !out_full;
  assign phase_o  = out_mem_q[rd_ptr_q];

  assign cur_rs    = cmd_i.is_init ? 1'b0 : cmd_i.reg_select;
  assign cur_value = cmd_i.is_init ? init_byte(idx_q) : cmd_i.value;
  assign cur_ms    = cmd_i.is_init ? init_wait(idx_q) : cmd_i.wait_ms;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    bus_latch_d = bus_latch_q;
    cmd_pop_o   = 1'b0;
    ph          = '0;
    ph.reg_select = cur_rs;
    ph.data_bus   = bus_latch_q;
    unique case (state_q)
      ST_FIRST: begin
        if (cmd_i.is_init) begin
          // power-up idle phase, then clear the bus
          ph.then_wait_ms = POWER_UP_MS;
          if (emit) begin
            bus_latch_d = 8'h00;
            idx_d       = '0;
            state_d     = ST_SEL;
          end
        end else if (emit) begin
          state_d = ST_RISE;
        end
      end
      ST_SEL: begin
        if (emit) begin
          state_d = ST_RISE;
        end
      end
      ST_RISE: begin
        ph.enable   = 1'b1;
        ph.data_bus = cur_value;
        if (emit) begin
          state_d = ST_FALL;
        end
      end
      ST_FALL: begin
        ph.data_bus        = cur_value;
        ph.then_short_wait = 1'b1;
        ph.then_wait_ms    = cur_ms;
        ph.last = !(cmd_i.is_init && (idx_q != IDX_W'(INIT_BYTES - 1)));
        if (emit) begin
          bus_latch_d = cur_value;
          if (ph.last) begin
            cmd_pop_o = 1'b1;
            state_d   = ST_FIRST;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_SEL;
          end
        end
      end
      default: begin
        state_d = ST_FIRST;
      end
    endcase
  end

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = emit ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? bump(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (emit && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!emit && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FIRST;
      idx_q       <= '0;
      bus_latch_q <= 8'h00;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      bus_latch_q <= bus_latch_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_mem_q[wr_ptr_q] <= ph;
    end
  end

endmodule

// ===== sv/char_lcd_8bit_bus_sequencer.sv =====
// Character LCD 8-bit bus sequencer. Requests (init, write character, write
// command, set cursor, clear) go in through a queue-style port and come out
// as pin phases, one phase a cycle while the result queue has room: three for a
// byte request and 28 for init, so the rate is set by the phase sequencer in
// the back end stepping one phase per cycle. The front end classifies requests
// into a two-entry command queue, so a new request is taken while the previous
// one is still being played out. Cursor requests out of range and unknown
// functions give no phases. column_limit is written through the cfg channel,
// always ready. Depends on lcdseq_pkg, lcdseq_front, lcdseq_cmd_fifo and lcdseq_back.
module char_lcd_8bit_bus_sequencer import lcdseq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  req_t       req_i,
  output logic       empty,
  input  logic       pop,
  output phase_t     phase_o
);

  logic cmd_valid, cmd_full, cmd_empty, cmd_pop;
  cmd_t cmd_in, cmd_head;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full;

  lcdseq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (push && !cmd_full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in)
  );

  lcdseq_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_valid),
    .wr_data_i (cmd_in),
    .full_o    (cmd_full),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_head),
    .empty_o   (cmd_empty)
  );

  lcdseq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .phase_o     (phase_o)
  );

endmodule

// ===== sv/lcdseq_checker.sv =====
// Port-level checks on the sequencer's result side, and the bind that
// attaches them to the top level. Depends on lcdseq_pkg.
module lcdseq_checker import lcdseq_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   empty,
  input logic   pop,
  input phase_t phase_o
);

  // hold a waiting phase until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(phase_o)))
    else $error("waiting phase changed before pop");

  // the enable pulse is never the end of a request nor followed by a settle
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && phase_o.enable) |-> (!phase_o.last && !phase_o.then_short_wait))
    else $error("enable-high phase marked last or settled");

  a_ms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (phase_o.then_wait_ms == 7'd0 || phase_o.then_wait_ms == 7'd2 ||
                phase_o.then_wait_ms == 7'd5 || phase_o.then_wait_ms == 7'd15 ||
                phase_o.then_wait_ms == 7'd100))
    else $error("unexpected millisecond wait");

  // power-up phase is an idle command-register phase with no settle
  a_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && phase_o.then_wait_ms == POWER_UP_MS) |->
      (!phase_o.reg_select && !phase_o.enable && !phase_o.then_short_wait &&
       !phase_o.last))
    else $error("malformed power-up phase");

endmodule

bind char_lcd_8bit_bus_sequencer lcdseq_checker u_lcdseq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .empty   (empty),
  .pop     (pop),
  .phase_o (phase_o)
);
